FILE: sv/aalu_pkg.sv
`default_nettype none
package aalu_pkg;
	localparam int VALUE_BITS_DEF = 14;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_DIV = 3'd2,
		CMD_MUL = 3'd3,
		CMD_NEG = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DIV0   = 2'd1,
		ST_BADCMD = 2'd2
	} status_t;

	// control carried alongside the divider chain
	typedef struct packed {
		logic    vld;
		logic    neg;
		logic    is_div;
		status_t st;
	} aalu_ctl_t;
endpackage
`default_nettype wire

FILE: sv/aalu_cell.sv
`default_nettype none
// One restoring-division step: shifts one dividend bit into the remainder; non-division items pass through unchanged
module aalu_cell
	import aalu_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int STEP       = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  stall,
	input  wire aalu_ctl_t             ctl_i,
	input  wire logic [VALUE_BITS-1:0] rem_i,
	input  wire logic [VALUE_BITS-1:0] quo_i,
	input  wire logic [VALUE_BITS-1:0] dvs_i,
	input  wire logic [VALUE_BITS:0]   wrd_i,
	output aalu_ctl_t                  ctl_q,
	output logic [VALUE_BITS-1:0]      rem_q,
	output logic [VALUE_BITS-1:0]      quo_q,
	output logic [VALUE_BITS-1:0]      dvs_q,
	output logic [VALUE_BITS:0]        wrd_q
);
	localparam int BIT = VALUE_BITS - 1 - STEP;

	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS-1:0] rem_n;
	logic [VALUE_BITS-1:0] quo_n;

	// trial subtract
	always_comb begin
		trial = {rem_i, quo_i[BIT]} - {1'b0, dvs_i};
		quo_n = quo_i;
		if (!trial[VALUE_BITS]) begin
			rem_n      = trial[VALUE_BITS-1:0];
			quo_n[BIT] = ctl_i.is_div;
		end else begin
			rem_n      = {rem_i[VALUE_BITS-2:0], quo_i[BIT]};
			quo_n[BIT] = 1'b0;
		end
		if (!ctl_i.is_div) begin
			quo_n = quo_i;
			rem_n = rem_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (!stall) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			dvs_q <= dvs_i;
			wrd_q <= wrd_i;
		end
	end
endmodule
`default_nettype wire

FILE: sv/accumulator_alu_14bit_tagged.sv
`default_nettype none
// Accumulator ALU with tagged words (tag bit on top, two's-complement value below).
// Input channel: in_valid/in_stall with command, accumulator_in, operand_value.
// Output channel: out_valid/out_stall with accumulator_out, status, counter_advance.
// A transfer happens where valid is high and stall low.
// Pipeline: one entry stage that forms magnitudes, the product and early results,
// then a row of VALUE_BITS division cells (one quotient bit each), then the
// output register. Every item walks the whole cell row.
// Throughput: one item per cycle while the output is not stalled.
// When the receiver stalls, the whole row holds and in_stall follows out_stall
// while the output register is full, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module accumulator_alu_14bit_tagged
	import aalu_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          command,
	input  wire logic [VALUE_BITS:0] accumulator_in,
	input  wire logic [VALUE_BITS:0] operand_value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [VALUE_BITS:0]      accumulator_out,
	output logic [1:0]               status,
	output logic                     counter_advance
);
	localparam int N = VALUE_BITS;

	logic stall;
	assign stall    = out_valid && out_stall;
	assign in_stall = stall;

	// entry stage
	logic [N-1:0]   a, b, ma, mb, r0;
	logic [2*N-1:0] prod;
	logic           neg;
	aalu_ctl_t      ctl0;

	always_comb begin
		a    = accumulator_in[N-1:0];
		b    = operand_value[N-1:0];
		ma   = a[N-1] ? (N)'(-a) : a;
		mb   = b[N-1] ? (N)'(-b) : b;
		neg  = a[N-1] ^ b[N-1];
		prod = ma * mb;
		r0   = '0;
		ctl0.vld    = in_valid;
		ctl0.neg    = neg;
		ctl0.is_div = 1'b0;
		ctl0.st     = ST_OK;
		case (command)
			CMD_ADD: r0 = a + b;
			CMD_SUB: r0 = a - b;
			CMD_MUL: r0 = neg ? (N)'(-prod[N-1:0]) : prod[N-1:0];
			CMD_NEG: r0 = (N)'(-a);
			CMD_DIV: begin
				if (b == '0) ctl0.st = ST_DIV0;
				else ctl0.is_div = 1'b1;
			end
			default: ctl0.st = ST_BADCMD;
		endcase
	end

	aalu_ctl_t        ctl_c [N+1];
	logic [N-1:0]     rem_c [N+1];
	logic [N-1:0]     quo_c [N+1];
	logic [N-1:0]     dvs_c [N+1];
	logic [N:0]       wrd_c [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (!stall) begin
			ctl_c[0] <= ctl0;
		end
	end

	// quotient register holds dividend magnitude or the early result
	always_ff @(posedge clk) begin
		if (!stall) begin
			rem_c[0] <= '0;
			quo_c[0] <= ctl0.is_div ? ma : r0;
			dvs_c[0] <= mb;
			wrd_c[0] <= accumulator_in;
		end
	end

	// division row
	for (genvar i = 0; i < N; i++) begin : g_cell
		aalu_cell #(.VALUE_BITS(N), .STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .stall(stall),
			.ctl_i(ctl_c[i]), .rem_i(rem_c[i]), .quo_i(quo_c[i]),
			.dvs_i(dvs_c[i]), .wrd_i(wrd_c[i]),
			.ctl_q(ctl_c[i+1]), .rem_q(rem_c[i+1]), .quo_q(quo_c[i+1]),
			.dvs_q(dvs_c[i+1]), .wrd_q(wrd_c[i+1])
		);
	end

	// output register
	logic [N-1:0] qf;
	always_comb begin
		qf = quo_c[N];
		if (ctl_c[N].is_div && ctl_c[N].neg) qf = (N)'(-quo_c[N]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!stall) begin
			out_valid <= ctl_c[N].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			status          <= ctl_c[N].st;
			counter_advance <= (ctl_c[N].st == ST_OK);
			accumulator_out <= (ctl_c[N].st == ST_OK) ? {1'b1, qf} : wrd_c[N];
		end
	end
endmodule
`default_nettype wire

FILE: sv/aalu_checker.sv
`default_nettype none
module aalu_checker
	import aalu_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [VALUE_BITS:0] accumulator_out,
	input wire logic [1:0]          status,
	input wire logic                counter_advance
);
	// advance exactly on success
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (counter_advance == (status == ST_OK)))
		else $error("advance flag disagrees with status");
	// success carries the tag
	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> accumulator_out[VALUE_BITS])
		else $error("tag missing on result");
	// only defined status codes
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_DIV0 || status == ST_BADCMD))
		else $error("bad status code");
	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(accumulator_out)))
		else $error("stalled result changed");
	// input only stalls behind a stalled result
	a_install: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output stall");
endmodule

bind accumulator_alu_14bit_tagged aalu_checker #(.VALUE_BITS(VALUE_BITS)) u_chk (.*);
`default_nettype wire
